### sv/htdr_pkg.sv
`default_nettype none

package htdr_pkg;

   // beat widths on the stream ports
   localparam int REQ_DATA_W = 112;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 176;

   localparam int KEY_W   = 64;
   localparam int TAG_W   = 32;
   localparam int SCORE_W = 16;
   localparam int DEPTH_W = 8;
   localparam int BOUND_W = 2;
   localparam int MOVE_W  = 16;
   localparam int COUNT_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_STORE  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_REDUCE,
      ST_READ,
      ST_EXEC,
      ST_WIPE
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [SCORE_W-1:0] score;
      logic [DEPTH_W-1:0] depth;
      logic [BOUND_W-1:0] bound;
      logic [MOVE_W-1:0]  move;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic rd_req;
      logic rd_slot;
      logic reduce_step;
      logic wipe_step;
      logic clear_counts;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic reduce_last;
      logic wipe_last;
      logic direct_index;
   } status_type;

endpackage

`default_nettype wire

### sv/htdr_ctrl.sv
`default_nettype none

module htdr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic [1:0]             req_op,
   output logic                        req_tready,
   input  wire htdr_pkg::status_type   status,
   output htdr_pkg::cmd_type           cmd
);
   import htdr_pkg::*;

   state_type state_ff;
   state_type state_in;
   op_type    op;

   assign op = op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.wipe_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (op)
                  OP_STORE, OP_LOOKUP: begin
                     state_in = status.direct_index ? ST_EXEC : ST_REDUCE;
                  end
                  OP_CLEAR: begin
                     state_in = ST_WIPE;
                  end
                  default: begin
                     state_in = ST_EXEC;
                  end
               endcase
            end
         end
         ST_REDUCE: begin
            if (status.reduce_last) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_WIPE: begin
            if (status.wipe_last) state_in = ST_EXEC;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.wipe_step = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (op)
                  OP_STORE, OP_LOOKUP: begin
                     cmd.rd_req = status.direct_index;
                  end
                  OP_CLEAR: begin
                     cmd.clear_counts = 1'b1;
                  end
                  default: begin
                     cmd.rd_req = 1'b0;
                  end
               endcase
            end
         end
         ST_REDUCE: begin
            cmd.reduce_step = 1'b1;
         end
         ST_READ: begin
            cmd.rd_slot = 1'b1;
         end
         ST_EXEC: begin
            cmd.exec = status.out_free;
         end
         ST_WIPE: begin
            cmd.wipe_step = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/htdr_datapath.sv
`default_nettype none

module htdr_datapath #(
   parameter int TABLE_ENTRIES = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire htdr_pkg::cmd_type                    cmd,
   output htdr_pkg::status_type                      status,
   input  wire logic [htdr_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic [htdr_pkg::REQ_USER_W-1:0]      req_tuser,
   input  wire logic                                 rsp_tready,
   output logic                                      rsp_tvalid,
   output logic [htdr_pkg::RSP_DATA_W-1:0]           rsp_tdata
);
   import htdr_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int T_W   = IDX_W + 16;
   localparam logic DIRECT = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
   localparam logic [T_W-1:0] NVAL  = T_W'(TABLE_ENTRIES);
   localparam logic [T_W-1:0] NVAL2 = T_W'(2 * TABLE_ENTRIES);
   // 2^(IDX_W+16) / TABLE_ENTRIES, below 2^17 for every table size
   localparam logic [16:0] RECIP = 17'((64'd1 << (IDX_W + 16)) / 64'(TABLE_ENTRIES));
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c,
                                                  input logic en);
      logic [COUNT_W-1:0] r;
      r = c;
      if (en && (c != COUNT_MAX)) r = c + COUNT_W'(1);
      return r;
   endfunction

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_ff;

   // latched request
   logic [KEY_W-1:0]   key_ff;
   logic [SCORE_W-1:0] score_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [BOUND_W-1:0] bound_ff;
   logic [MOVE_W-1:0]  move_ff;
   op_type             op_ff;

   // slot and chunked modulo
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [1:0]       chunk_ff, chunk_in;
   logic             fix_ff, fix_in;
   logic [15:0]      qest_ff, qest_in;
   logic [15:0]      chunk;
   logic [T_W-1:0]   part;
   logic [33:0]      qprod;
   logic [T_W-1:0]   diff;
   logic [IDX_W-1:0] rem_next;

   logic [IDX_W-1:0] wipe_ff, wipe_in;

   logic [COUNT_W-1:0] stores_ff, stores_in;
   logic [COUNT_W-1:0] probes_ff, probes_in;
   logic [COUNT_W-1:0] hits_ff, hits_in;
   logic [COUNT_W-1:0] colls_ff, colls_in;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [TAG_W-1:0] tag;
   logic             take, coll, hit;
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] waddr, raddr;
   entry_type        wdata;

   assign tag = key_ff[TAG_W-1:0];

   assign take = (op_ff == OP_STORE) && ((rd_ff.tag == '0) || (depth_ff > rd_ff.depth));
   assign coll = take && (rd_ff.tag != '0) && (rd_ff.tag != tag);
   assign hit  = (op_ff == OP_LOOKUP) && (rd_ff.tag != '0) && (rd_ff.tag == tag)
                 && (rd_ff.depth >= depth_ff);

   // 16 key bits per chunk, most significant chunk first
   assign chunk = 16'(key_ff >> {chunk_ff, 4'b0000});
   assign part  = {rem_ff, chunk};

   // quotient estimate from the top 17 bits, at most two below the true one
   assign qprod = 34'(part[T_W-1:IDX_W-1]) * 34'(RECIP);
   assign diff  = part - (T_W'(qest_ff) * NVAL);

   always_comb begin
      priority if (diff >= NVAL2) begin
         rem_next = IDX_W'(diff - NVAL2);
      end else if (diff >= NVAL) begin
         rem_next = IDX_W'(diff - NVAL);
      end else begin
         rem_next = IDX_W'(diff);
      end
   end

   // two steps per chunk: estimate, then subtract and fix up
   always_comb begin
      rem_in   = rem_ff;
      chunk_in = chunk_ff;
      fix_in   = fix_ff;
      qest_in  = qest_ff;
      if (cmd.accept) begin
         rem_in   = DIRECT ? req_tdata[IDX_W-1:0] : '0;
         chunk_in = 2'd3;
         fix_in   = 1'b0;
      end else if (cmd.reduce_step) begin
         fix_in = !fix_ff;
         if (!fix_ff) begin
            qest_in = qprod[32:17];
         end else begin
            rem_in   = rem_next;
            chunk_in = chunk_ff - 2'd1;
         end
      end
   end

   always_comb begin
      wipe_in = wipe_ff;
      if (cmd.wipe_step) wipe_in = (wipe_ff == LAST_IDX) ? '0 : wipe_ff + IDX_W'(1);
   end

   always_comb begin
      stores_in = stores_ff;
      probes_in = probes_ff;
      hits_in   = hits_ff;
      colls_in  = colls_ff;
      if (cmd.clear_counts) begin
         stores_in = '0;
         probes_in = '0;
         hits_in   = '0;
         colls_in  = '0;
      end else if (cmd.exec) begin
         stores_in = sat_inc(stores_ff, take);
         probes_in = sat_inc(probes_ff, op_ff == OP_LOOKUP);
         hits_in   = sat_inc(hits_ff, hit);
         colls_in  = sat_inc(colls_ff, coll);
      end
   end

   assign mem_we = cmd.wipe_step | (cmd.exec & take);
   assign mem_re = cmd.rd_req | cmd.rd_slot;
   assign waddr  = cmd.wipe_step ? wipe_ff : rem_ff;
   assign raddr  = cmd.rd_req ? req_tdata[IDX_W-1:0] : rem_ff;

   always_comb begin
      wdata = '0;
      if (!cmd.wipe_step) begin
         wdata.tag   = tag;
         wdata.score = score_ff;
         wdata.depth = depth_ff;
         wdata.bound = bound_ff;
         wdata.move  = move_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[waddr] <= wdata;
      if (mem_re) rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff   <= req_tdata[63:0];
         score_ff <= req_tdata[79:64];
         depth_ff <= req_tdata[87:80];
         bound_ff <= req_tdata[89:88];
         move_ff  <= req_tdata[105:90];
         op_ff    <= op_type'(req_tuser);
      end
      rem_ff   <= rem_in;
      chunk_ff <= chunk_in;
      fix_ff   <= fix_in;
      qest_ff  <= qest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_ff   <= '0;
         stores_ff <= '0;
         probes_ff <= '0;
         hits_ff   <= '0;
         colls_ff  <= '0;
      end else begin
         wipe_ff   <= wipe_in;
         stores_ff <= stores_in;
         probes_ff <= probes_in;
         hits_ff   <= hits_in;
         colls_ff  <= colls_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_data_ff <= {4'b0, colls_in, hits_in, probes_in, stores_in, take,
                         hit ? rd_ff.move  : {MOVE_W{1'b0}},
                         hit ? rd_ff.bound : {BOUND_W{1'b0}},
                         hit ? rd_ff.depth : {DEPTH_W{1'b0}},
                         hit ? rd_ff.score : {SCORE_W{1'b0}},
                         hit};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.out_free     = !rsp_valid_ff || rsp_tready;
   assign status.reduce_last  = (chunk_ff == 2'd0) && fix_ff;
   assign status.wipe_last    = (wipe_ff == LAST_IDX);
   assign status.direct_index = DIRECT;

endmodule

`default_nettype wire

### sv/hashed_table_depth_replace_unit.sv
`default_nettype none

// Direct-mapped transposition table with depth-preferred replacement. Each
// request beat carries an operation in req_tuser: store writes the slot picked
// by position_key mod TABLE_ENTRIES when the slot is empty (tag zero) or the
// new depth is greater than the stored one, lookup hits on a nonzero matching
// tag with stored depth at least the asked depth, clear empties the table and
// zeroes the four saturating counters; code three only reports the counters.
// Every request beat gives exactly one response beat. With a power-of-two
// TABLE_ENTRIES a store or lookup does a registered slot read, then a
// compare and write back; with any other size the slot comes from a modulo
// unit that folds the key in four 16-bit chunks, each taking a reciprocal
// multiply estimate and then a subtract with fix-up, before the slot read. A
// clear writes one table row per cycle. After reset the same clearing pass
// runs with req_tready low. The response register lets a new request be
// taken while a response beat waits.

module hashed_table_depth_replace_unit #(
   parameter int TABLE_ENTRIES = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // position_key[63:0], search_score[79:64], search_depth[87:80],
   // bound_kind[89:88], move_code[105:90], zero fill above
   input  wire logic [htdr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation[1:0]
   input  wire logic [htdr_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // hit[0], found_score[16:1], found_depth[24:17], found_bound[26:25],
   // found_move[42:27], written[43], stores_total[75:44],
   // probes_total[107:76], hits_total[139:108], collisions_total[171:140],
   // zero fill above
   output logic [htdr_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import htdr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: sweep, modulo steps, read, execute
   htdr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // table memory, counters and response register
   htdr_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

### tb/hashed_table_depth_replace_unit_test.sv
`default_nettype none

module hashed_table_depth_replace_unit_test;
   import htdr_pkg::*;

   localparam int SLOTS = 1024;
   localparam int RAND_ITEMS = 950;
   localparam int POOL_N = 24;
   localparam int MAX_REPORTS = 10;
   localparam int TAIL_CYCLES = 100;
   // code three is not an operation, the block only reports its counters
   localparam logic [1:0] OP_NONE = 2'd3;

   // one request beat plus a flag that holds it back until every awaited response is in
   typedef struct {
      logic [1:0]         op;
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
      logic [DEPTH_W-1:0] depth;
      logic [BOUND_W-1:0] bound;
      logic [MOVE_W-1:0]  move;
      bit                 drain;
   } tt_request;

   // response beat, highest field first
   typedef struct packed {
      logic [RSP_DATA_W-173:0] fill;
      logic [COUNT_W-1:0]      collisions;
      logic [COUNT_W-1:0]      hits;
      logic [COUNT_W-1:0]      probes;
      logic [COUNT_W-1:0]      stores;
      logic                    written;
      logic [MOVE_W-1:0]       move;
      logic [BOUND_W-1:0]      bound;
      logic [DEPTH_W-1:0]      depth;
      logic [SCORE_W-1:0]      score;
      logic                    hit;
   } tt_response;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   tt_request cur_req = '{default: '0};

   always #4 clock = ~clock;

   // beat layout: key, score, depth, bound, move from the lowest bit up
   assign req_tdata = {{(REQ_DATA_W - 106){1'b0}}, cur_req.move, cur_req.bound,
                       cur_req.depth, cur_req.score, cur_req.key};
   assign req_tuser = cur_req.op;

   hashed_table_depth_replace_unit #(
      .TABLE_ENTRIES(SLOTS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // ------------------------------------------------------------------
   // shadow copy of the table and its counters
   // ------------------------------------------------------------------
   logic [TAG_W-1:0]   tag_mem   [SLOTS];
   logic [SCORE_W-1:0] score_mem [SLOTS];
   logic [DEPTH_W-1:0] depth_mem [SLOTS];
   logic [BOUND_W-1:0] bound_mem [SLOTS];
   logic [MOVE_W-1:0]  move_mem  [SLOTS];
   logic [COUNT_W-1:0] n_stores, n_probes, n_hits, n_collisions;

   tt_request  pending [$];   // beats not yet offered
   tt_response awaited [$];   // predicted responses in beat order

   int unsigned n_sent = 0;
   int unsigned n_accepted = 0;
   int unsigned errors = 0;

   function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic void table_wipe();
      for (int i = 0; i < SLOTS; i++) begin
         tag_mem[i] = '0;
         score_mem[i] = '0;
         depth_mem[i] = '0;
         bound_mem[i] = '0;
         move_mem[i] = '0;
      end
      n_stores = '0;
      n_probes = '0;
      n_hits = '0;
      n_collisions = '0;
   endfunction

   // applies one beat to the shadow table and returns the response it gives
   function automatic tt_response table_apply(input tt_request r);
      tt_response res;
      int unsigned s;
      logic [TAG_W-1:0] tag;
      res = '0;
      s = int'(r.key % SLOTS);
      tag = r.key[TAG_W-1:0];
      case (r.op)
         OP_STORE: begin
            // empty slot or strictly deeper search wins the slot
            if (tag_mem[s] == '0 || r.depth > depth_mem[s]) begin
               if (tag_mem[s] != '0 && tag_mem[s] != tag)
                  n_collisions = sat_bump(n_collisions);
               tag_mem[s] = tag;
               score_mem[s] = r.score;
               depth_mem[s] = r.depth;
               bound_mem[s] = r.bound;
               move_mem[s] = r.move;
               n_stores = sat_bump(n_stores);
               res.written = 1'b1;
            end
         end
         OP_LOOKUP: begin
            n_probes = sat_bump(n_probes);
            if (tag_mem[s] != '0 && tag_mem[s] == tag && depth_mem[s] >= r.depth) begin
               n_hits = sat_bump(n_hits);
               res.hit = 1'b1;
               res.score = score_mem[s];
               res.depth = depth_mem[s];
               res.bound = bound_mem[s];
               res.move = move_mem[s];
            end
         end
         OP_CLEAR: table_wipe();
         default: ;
      endcase
      res.stores = n_stores;
      res.probes = n_probes;
      res.hits = n_hits;
      res.collisions = n_collisions;
      return res;
   endfunction

   task automatic note_error(input string what, input logic [31:0] want, input logic [31:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("mismatch %s: expected %h, got %h", what, want, got);
   endtask

   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (want !== got)
         note_error(what, want, got);
   endtask

   task automatic push_req(input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input logic [SCORE_W-1:0] score, input logic [DEPTH_W-1:0] depth,
                           input logic [BOUND_W-1:0] bound, input logic [MOVE_W-1:0] move,
                           input bit drain);
      tt_request r;
      r.op = op;
      r.key = key;
      r.score = score;
      r.depth = depth;
      r.bound = bound;
      r.move = move;
      r.drain = drain;
      pending.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // rising edge: predict accepted request beats, check response beats
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      tt_response want;
      tt_response got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            awaited.push_back(table_apply(cur_req));
            n_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (awaited.size() == 0) begin
               note_error("unexpected response beat", '0, rsp_tdata[31:0]);
            end else begin
               want = awaited.pop_front();
               check_field("hit", 32'(want.hit), 32'(got.hit));
               check_field("found_score", 32'(want.score), 32'(got.score));
               check_field("found_depth", 32'(want.depth), 32'(got.depth));
               check_field("found_bound", 32'(want.bound), 32'(got.bound));
               check_field("found_move", 32'(want.move), 32'(got.move));
               check_field("written", 32'(want.written), 32'(got.written));
               check_field("stores_total", want.stores, got.stores);
               check_field("probes_total", want.probes, got.probes);
               check_field("hits_total", want.hits, got.hits);
               check_field("collisions_total", want.collisions, got.collisions);
               check_field("zero fill", 32'(want.fill), 32'(got.fill));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // request driver: bursts with random gaps, changes on the falling edge
   // ------------------------------------------------------------------
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;

   always @(negedge clock) begin
      logic next_valid;
      next_valid = 1'b0;
      if (!reset) begin
         if (req_tvalid && n_accepted < n_sent) begin
            // beat still waiting for ready
            next_valid = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (pending.size() > 0 && !(pending[0].drain && awaited.size() > 0)) begin
            cur_req <= pending.pop_front();
            n_sent++;
            next_valid = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else if ($urandom_range(0, 7) == 0) begin
               // long stretch with no idling
               burst_left = $urandom_range(30, 80);
               gap_left = 0;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_tvalid <= next_valid;
   end

   // ------------------------------------------------------------------
   // response side: one of four stall styles, each kept for a random stretch of cycles
   // ------------------------------------------------------------------
   int unsigned stall_mode = 0;
   int unsigned mode_cycles = 0;
   int unsigned slow_count = 0;

   always @(negedge clock) begin
      if (mode_cycles == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_cycles = $urandom_range(100, 400);
      end else begin
         mode_cycles--;
      end
      slow_count = (slow_count + 1) % 6;
      case (stall_mode)
         0: rsp_tready <= 1'b1;                             // always ready
         1: rsp_tready <= 1'($urandom_range(0, 1));         // coin flip
         2: rsp_tready <= (slow_count == 0);                // long stalls
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // ------------------------------------------------------------------
   // stimulus, reset and end of run
   // ------------------------------------------------------------------
   initial begin
      logic [KEY_W-1:0] pool [POOL_N];
      logic [KEY_W-1:0] key;
      logic [1:0] op;
      int unsigned pick;
      logic [KEY_W-1:0] key_a, key_b, key_d, key_e;
      key_a = 64'h0123_4567_89AB_C123;
      key_b = 64'h0123_4567_0000_1123;    // same slot as key_a, other tag
      key_d = 64'h0000_0000_1111_1222;
      key_e = 64'h0000_0000_2222_2222;    // same slot as key_d, other tag

      table_wipe();

      // directed: empty table, depth rule, collisions, zero tag, clear
      push_req(OP_LOOKUP, key_a, 16'h0000, 8'd0, 2'd0, 16'h0000, 0);
      push_req(OP_STORE, key_a, 16'h8000, 8'd0, 2'd0, 16'h0000, 0);
      push_req(OP_LOOKUP, key_a, 16'h0000, 8'd0, 2'd0, 16'h0000, 0);
      push_req(OP_LOOKUP, key_a, 16'h0000, 8'd1, 2'd0, 16'h0000, 0);
      push_req(OP_STORE, key_a, 16'h1234, 8'd0, 2'd1, 16'h0001, 0);  // equal depth keeps old
      push_req(OP_STORE, key_a, 16'h7FFF, 8'd255, 2'd3, 16'hFFFF, 0);
      push_req(OP_LOOKUP, key_a, 16'h0000, 8'd255, 2'd0, 16'h0000, 0);
      push_req(OP_STORE, key_b, 16'h5555, 8'd255, 2'd1, 16'hAAAA, 0);
      push_req(OP_STORE, key_d, 16'hFF00, 8'd5, 2'd2, 16'h1357, 0);
      push_req(OP_STORE, key_e, 16'h00FF, 8'd6, 2'd1, 16'h2468, 0);  // collision
      push_req(OP_LOOKUP, key_e, 16'h0000, 8'd6, 2'd0, 16'h0000, 0);
      push_req(OP_LOOKUP, key_d, 16'h0000, 8'd0, 2'd0, 16'h0000, 0);
      push_req(OP_STORE, 64'hFFFF_FFFF_0000_0000, 16'h0ABC, 8'd9, 2'd2, 16'h0DEF, 0);
      push_req(OP_LOOKUP, 64'hFFFF_FFFF_0000_0000, 16'h0000, 8'd0, 2'd0, 16'h0000, 0);
      push_req(OP_STORE, 64'h0000_0000_0000_0400, 16'h0042, 8'd1, 2'd0, 16'h0777, 0);
      push_req(OP_LOOKUP, 64'h0000_0000_0000_0400, 16'h0000, 8'd1, 2'd0, 16'h0000, 0);
      push_req(OP_NONE, '1, 16'hFFFF, 8'd255, 2'd3, 16'hFFFF, 0);
      push_req(OP_CLEAR, key_a, 16'h0000, 8'd0, 2'd0, 16'h0000, 1);  // after a full drain
      push_req(OP_LOOKUP, key_a, 16'h0000, 8'd0, 2'd0, 16'h0000, 0);
      push_req(OP_STORE, '1, 16'hFFFF, 8'd255, 2'd2, 16'hFFFF, 0);
      push_req(OP_LOOKUP, '1, 16'h0000, 8'd128, 2'd0, 16'h0000, 0);
      push_req(OP_STORE, '0, 16'h0000, 8'd0, 2'd0, 16'h0000, 0);

      // random: a small key pool keeps slots busy so hits and replacements happen
      for (int i = 0; i < POOL_N; i++)
         pool[i] = {$urandom, $urandom};
      for (int n = 0; n < RAND_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 2)
            op = OP_CLEAR;
         else if (pick < 5)
            op = OP_NONE;
         else if (pick < 52)
            op = OP_STORE;
         else
            op = OP_LOOKUP;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: key = pool[$urandom_range(0, POOL_N - 1)];
            // same slot, different tag
            6: key = pool[$urandom_range(0, POOL_N - 1)] ^ (64'($urandom_range(1, 22'h3F_FFFF)) << 10);
            7: key = {$urandom, 32'h0};     // zero tag
            default: begin
               key = {$urandom, $urandom};
               if (op == OP_STORE && $urandom_range(0, 1) == 1)
                  pool[$urandom_range(0, POOL_N - 1)] = key;
            end
         endcase
         push_req(op, key, 16'($urandom),
                  8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12)),
                  2'($urandom_range(0, 3)), 16'($urandom), (n % 300) == 150);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending.size() > 0 || req_tvalid || awaited.size() > 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (errors == 0 && awaited.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // hard stop if responses never arrive
   initial begin
      #8_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
